### sv/pru_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and command type of the pixel replicate upscaler.
package pru_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int ADDR_W     = $clog2(MAX_WIDTH);
    localparam int CNT_W      = $clog2(MAX_WIDTH + 1);
    localparam int RGB_W      = 24;
    localparam int SCALE_W    = 7;
    localparam int WIDTH_W    = 12;
    localparam int CFG_DATA_W = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic [SCALE_W-1:0] SCALE_MAX = 7'd100;

    localparam logic [1:0] KIND_PIXEL = 2'd0;
    localparam logic [1:0] KIND_PAD   = 2'd1;
    localparam logic [1:0] KIND_DROP  = 2'd2;

    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_TICK  = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 1'd1;

    typedef struct packed {
        logic              wr;
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr;
        logic [RGB_W-1:0]  rgb;
        logic              rend;
        logic              done;
    } t_cmd;

endpackage

### sv/pru_front.sv
`timescale 1ns / 1ps
// Front end: configuration registers, row counters and classification of transfers.
module pru_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [pru_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_accept,
    input  logic                           i_op,
    input  logic [pru_pkg::RGB_W-1:0]      i_rgb,
    output logic                           o_push,
    output pru_pkg::t_cmd                  o_cmd
);

    logic [pru_pkg::SCALE_W-1:0] r_scale;
    logic [pru_pkg::WIDTH_W-1:0] r_width;
    logic [pru_pkg::CNT_W-1:0]   r_load_count, n_load_count;
    logic                        r_replaying, n_replaying;
    logic [pru_pkg::SCALE_W-1:0] r_row_repeat, n_row_repeat;
    logic [pru_pkg::CNT_W-1:0]   r_pixel_index, n_pixel_index;
    logic [pru_pkg::SCALE_W-1:0] r_copy_count, n_copy_count;
    logic [1:0]                  r_pad_count, n_pad_count;

    logic [pru_pkg::SCALE_W-1:0] eff_s;
    logic [pru_pkg::CNT_W-1:0]   eff_w;
    logic [3:0]                  pad_prod;
    logic [1:0]                  pad;
    logic [pru_pkg::SCALE_W:0]   copy_inc;
    logic [pru_pkg::SCALE_W:0]   row_inc;
    logic                        rend;
    logic                        done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scale <= pru_pkg::SCALE_W'(1);
            r_width <= pru_pkg::WIDTH_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                pru_pkg::CFG_SCALE: r_scale <= i_cfg_data[pru_pkg::SCALE_W-1:0];
                pru_pkg::CFG_WIDTH: r_width <= i_cfg_data[pru_pkg::WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_scale == '0) begin
            eff_s = pru_pkg::SCALE_W'(1);
        end else if (r_scale > pru_pkg::SCALE_MAX) begin
            eff_s = pru_pkg::SCALE_MAX;
        end else begin
            eff_s = r_scale;
        end
        if (r_width == '0) begin
            eff_w = pru_pkg::CNT_W'(1);
        end else if (int'(r_width) > pru_pkg::MAX_WIDTH) begin
            eff_w = pru_pkg::CNT_W'(pru_pkg::MAX_WIDTH);
        end else begin
            eff_w = pru_pkg::CNT_W'(r_width);
        end
        pad_prod = 4'(eff_w[1:0]) * 4'(eff_s[1:0]);
        pad      = pad_prod[1:0];
    end

    always_comb begin
        n_load_count  = r_load_count;
        n_replaying   = r_replaying;
        n_row_repeat  = r_row_repeat;
        n_pixel_index = r_pixel_index;
        n_copy_count  = r_copy_count;
        n_pad_count   = r_pad_count;
        o_push        = 1'b0;
        o_cmd         = '0;
        copy_inc      = {1'b0, r_copy_count} + 1'b1;
        row_inc       = {1'b0, r_row_repeat} + 1'b1;
        rend          = 1'b0;
        done          = 1'b0;
        if (i_accept) begin
            if (i_op == pru_pkg::OP_PIXEL) begin
                if (r_replaying) begin
                    o_push     = 1'b1;
                    o_cmd.kind = pru_pkg::KIND_DROP;
                end else begin
                    if (r_load_count < pru_pkg::CNT_W'(pru_pkg::MAX_WIDTH)) begin
                        o_push     = 1'b1;
                        o_cmd.wr   = 1'b1;
                        o_cmd.addr = r_load_count[pru_pkg::ADDR_W-1:0];
                        o_cmd.rgb  = i_rgb;
                    end
                    n_load_count = r_load_count + 1'b1;
                    if (n_load_count >= eff_w) begin
                        n_replaying   = 1'b1;
                        n_row_repeat  = '0;
                        n_pixel_index = '0;
                        n_copy_count  = '0;
                        n_pad_count   = '0;
                    end
                end
            end else if (r_replaying) begin
                o_push = 1'b1;
                if (r_pixel_index < eff_w) begin
                    o_cmd.kind = pru_pkg::KIND_PIXEL;
                    o_cmd.addr = r_pixel_index[pru_pkg::ADDR_W-1:0];
                    if (copy_inc >= {1'b0, eff_s}) begin
                        n_copy_count  = '0;
                        n_pixel_index = r_pixel_index + 1'b1;
                    end else begin
                        n_copy_count = copy_inc[pru_pkg::SCALE_W-1:0];
                    end
                    rend = (n_pixel_index >= eff_w) && (pad == 2'd0);
                end else begin
                    o_cmd.kind  = pru_pkg::KIND_PAD;
                    n_pad_count = r_pad_count + 1'b1;
                    rend        = (n_pad_count == 2'd0) || (n_pad_count >= pad);
                end
                if (rend) begin
                    n_pixel_index = '0;
                    n_copy_count  = '0;
                    n_pad_count   = '0;
                    if (row_inc >= {1'b0, eff_s}) begin
                        done         = 1'b1;
                        n_replaying  = 1'b0;
                        n_load_count = '0;
                        n_row_repeat = '0;
                    end else begin
                        n_row_repeat = row_inc[pru_pkg::SCALE_W-1:0];
                    end
                end
                o_cmd.rend = rend;
                o_cmd.done = done;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_load_count  <= '0;
            r_replaying   <= 1'b0;
            r_row_repeat  <= '0;
            r_pixel_index <= '0;
            r_copy_count  <= '0;
            r_pad_count   <= '0;
        end else begin
            r_load_count  <= n_load_count;
            r_replaying   <= n_replaying;
            r_row_repeat  <= n_row_repeat;
            r_pixel_index <= n_pixel_index;
            r_copy_count  <= n_copy_count;
            r_pad_count   <= n_pad_count;
        end
    end

endmodule

### sv/pru_fifo.sv
`timescale 1ns / 1ps
// Short command queue between the front end and the back end.
module pru_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pru_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output pru_pkg::t_cmd o_head
);

    pru_pkg::t_cmd r_entry [pru_pkg::FIFO_DEPTH];
    logic [pru_pkg::FIFO_AW-1:0] r_wr_ptr;
    logic [pru_pkg::FIFO_AW-1:0] r_rd_ptr;
    logic [pru_pkg::FIFO_AW:0]   r_count;
    logic                        do_pop;

    assign o_full  = (r_count == (pru_pkg::FIFO_AW + 1)'(pru_pkg::FIFO_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_entry[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### sv/pru_back.sv
`timescale 1ns / 1ps
// Back end: line buffer, read stage and output register.
module pru_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_head_valid,
    input  pru_pkg::t_cmd             i_head,
    output logic                      o_pop,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [pru_pkg::RGB_W-1:0] o_rgb,
    output logic [1:0]                o_kind,
    output logic                      o_rend,
    output logic                      o_done
);

    logic [pru_pkg::RGB_W-1:0] r_mem [pru_pkg::MAX_WIDTH];
    logic [pru_pkg::RGB_W-1:0] r_rd_data;
    logic                      r_s1_valid;
    logic [1:0]                r_s1_kind;
    logic                      r_s1_rend;
    logic                      r_s1_done;
    logic                      r_out_valid;
    logic [pru_pkg::RGB_W-1:0] r_out_rgb;
    logic [1:0]                r_out_kind;
    logic                      r_out_rend;
    logic                      r_out_done;
    logic                      s1_adv;
    logic                      s1_free;
    logic                      pop_rd;

    assign s1_adv  = r_s1_valid && (!r_out_valid || i_ready);
    assign s1_free = !r_s1_valid || s1_adv;
    assign o_pop   = i_head_valid && (i_head.wr || s1_free);
    assign pop_rd  = o_pop && !i_head.wr;

    always_ff @(posedge i_clk) begin
        if (o_pop && i_head.wr) begin
            r_mem[i_head.addr] <= i_head.rgb;
        end
        if (pop_rd) begin
            r_rd_data <= r_mem[i_head.addr];
            r_s1_kind <= i_head.kind;
            r_s1_rend <= i_head.rend;
            r_s1_done <= i_head.done;
        end
        if (s1_adv) begin
            r_out_rgb  <= (r_s1_kind == pru_pkg::KIND_PIXEL) ? r_rd_data : '0;
            r_out_kind <= r_s1_kind;
            r_out_rend <= r_s1_rend;
            r_out_done <= r_s1_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (pop_rd) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_rgb   = r_out_rgb;
    assign o_kind  = r_out_kind;
    assign o_rend  = r_out_rend;
    assign o_done  = r_out_done;

endmodule

### sv/pixel_replicate_upscaler_core.sv
`timescale 1ns / 1ps
// Top level of the integer nearest-neighbour pixel replicate upscaler.
// The block takes one transfer per clock cycle while the command queue has room, pixels and
// output ticks alike, and delivers at most one result per cycle; the single-port line buffer,
// which does either one pixel write or one pixel read in a cycle, sets that rate. A result
// passes through the command queue and the line-buffer read register, and then it waits in
// the output register until it is taken.
// A pixel that arrives while a row is being replayed is not
// stored but answered with a drop result. Ticks while a row is still loading give nothing.
// The line buffer needs no clearing after reset. Write the configuration only while idle.
module pixel_replicate_upscaler_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [pru_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                           i_s_axis_tvalid,
    output logic                           o_s_axis_tready,
    input  logic [23:0]                    i_s_axis_tdata,  // blue_in, green_in, red_in
    input  logic                           i_s_axis_tuser,  // operation
    output logic                           o_m_axis_tvalid,
    input  logic                           i_m_axis_tready,
    output logic [23:0]                    o_m_axis_tdata,  // blue_out, green_out, red_out
    output logic [2:0]                     o_m_axis_tuser,  // kind, source_row_done
    output logic                           o_m_axis_tlast
);

    logic          fifo_full;
    logic          fifo_valid;
    logic          push;
    logic          pop;
    logic          accept;
    pru_pkg::t_cmd push_cmd;
    pru_pkg::t_cmd head_cmd;
    logic [1:0]    out_kind;
    logic          out_done;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = !fifo_full;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    pru_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_op        (i_s_axis_tuser),
        .i_rgb       (i_s_axis_tdata),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    pru_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (fifo_full),
        .i_pop   (pop),
        .o_valid (fifo_valid),
        .o_head  (head_cmd)
    );

    pru_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (fifo_valid),
        .i_head       (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_rgb        (o_m_axis_tdata),
        .o_kind       (out_kind),
        .o_rend       (o_m_axis_tlast),
        .o_done       (out_done)
    );

    assign o_m_axis_tuser = {out_done, out_kind};

    a_drop_no_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && out_kind == pru_pkg::KIND_DROP) |-> (!o_m_axis_tlast && !out_done))
        else $error("drop result carries row flags");

    a_done_ends_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && out_done) |-> o_m_axis_tlast)
        else $error("source row finished without ending an output row");

    a_only_pixels_have_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && out_kind != pru_pkg::KIND_PIXEL) |-> (o_m_axis_tdata == '0))
        else $error("non-pixel result carries data");

    a_no_output_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid straight after reset");

endmodule
